FILE: rtl/ncq_pkg.sv
// ----------------------------------------------------------------------------
// ncq_pkg: shared types and constants of the nearest codeword quantizer
// Operation and register codes, fixed field widths, controller state and
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ncq_pkg;

	localparam int INDEX_W      = 8;  // entry_index and nearest_index
	localparam int ACTIVE_W     = 9;  // active_codewords register
	localparam int DIM_CODE_W   = 2;  // dimension_code register
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 9;
	localparam int N_COMPONENTS = 8;  // components carried by one item

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUANT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIM    = 1'b1;

	localparam logic [ACTIVE_W-1:0]   ACTIVE_RST = 9'd256;
	localparam logic [DIM_CODE_W-1:0] DIM_RST    = 2'd0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_WAIT,
		ST_RESULT
	} ncq_state_t;

	typedef struct packed {
		logic                  wr_en;       // write the item's codeword
		logic                  start;       // capture vector for a search
		logic [DIM_CODE_W-1:0] dim_code;
		logic                  rd_en;       // read one codeword row
		logic                  rd_first;
		logic                  rd_last;
		logic                  load_result; // move best index to output
	} ncq_cmd_t;

	typedef struct packed {
		logic done;                         // last distance compared
	} ncq_stat_t;

endpackage

FILE: rtl/ncq_if.sv
// ----------------------------------------------------------------------------
// ncq_if: valid/ready channels of the nearest codeword quantizer
// Request channel carrying load or quantize items, response channel
// carrying the index of the nearest codeword.
// ----------------------------------------------------------------------------
interface ncq_req_if #(parameter int COMPONENT_BITS = 16);
	logic                             valid;
	logic                             ready;
	logic                             op;
	logic [7:0]                       entry_index;
	logic signed [COMPONENT_BITS-1:0] component_0;
	logic signed [COMPONENT_BITS-1:0] component_1;
	logic signed [COMPONENT_BITS-1:0] component_2;
	logic signed [COMPONENT_BITS-1:0] component_3;
	logic signed [COMPONENT_BITS-1:0] component_4;
	logic signed [COMPONENT_BITS-1:0] component_5;
	logic signed [COMPONENT_BITS-1:0] component_6;
	logic signed [COMPONENT_BITS-1:0] component_7;
	logic                             last_vector;

	modport source (
		output valid, op, entry_index, last_vector,
		output component_0, component_1, component_2, component_3,
		output component_4, component_5, component_6, component_7,
		input  ready
	);
	modport sink (
		input  valid, op, entry_index, last_vector,
		input  component_0, component_1, component_2, component_3,
		input  component_4, component_5, component_6, component_7,
		output ready
	);
endinterface

interface ncq_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] nearest_index;
	logic       batch_end;

	modport source (output valid, nearest_index, batch_end, input ready);
	modport sink (input valid, nearest_index, batch_end, output ready);
endinterface

FILE: rtl/ncq_ctrl.sv
// ----------------------------------------------------------------------------
// ncq_ctrl: controller of the nearest codeword quantizer
// Holds the configuration registers, sequences the codebook reads of a
// search and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module ncq_ctrl import ncq_pkg::*; #(
	parameter int MAX_CODEWORDS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	input  logic                  in_op,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [$clog2(MAX_CODEWORDS)-1:0] rd_addr,
	output ncq_cmd_t              cmd,
	input  ncq_stat_t             stat
);

	localparam int IDX_W = $clog2(MAX_CODEWORDS);

	ncq_state_t            state_q, state_d;
	logic [ACTIVE_W-1:0]   active_q;
	logic [DIM_CODE_W-1:0] dim_code_q;
	logic [IDX_W-1:0]      cnt_q, cnt_d;
	logic [IDX_W-1:0]      last_q, last_d;
	logic [IDX_W-1:0]      count_m1;
	logic                  out_valid_q;

	// zero searches slot 0 alone, oversize saturates to the codebook depth
	always_comb begin
		if (active_q == '0) begin
			count_m1 = '0;
		end else if (active_q > ACTIVE_W'(MAX_CODEWORDS)) begin
			count_m1 = IDX_W'(MAX_CODEWORDS - 1);
		end else begin
			count_m1 = IDX_W'(active_q - ACTIVE_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= ACTIVE_RST;
			dim_code_q <= DIM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACTIVE: active_q   <= cfg_wdata[ACTIVE_W-1:0];
				CFG_DIM:    dim_code_q <= cfg_wdata[DIM_CODE_W-1:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			last_q  <= last_d;
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d         = state_q;
		cnt_d           = cnt_q;
		last_d          = last_q;
		in_ready        = 1'b0;
		cmd             = '0;
		cmd.dim_code    = dim_code_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == OP_LOAD) begin
						cmd.wr_en = 1'b1;
					end else begin
						cmd.start = 1'b1;
						cnt_d     = '0;
						last_d    = count_m1;
						state_d   = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_first = (cnt_q == '0);
				cmd.rd_last  = (cnt_q == last_q);
				cnt_d        = cnt_q + IDX_W'(1);
				if (cmd.rd_last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (stat.done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				// hold the best index until the output register frees up
				if (!out_valid_q || out_ready) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign rd_addr   = cnt_q;
	assign out_valid = out_valid_q;

endmodule

FILE: rtl/ncq_datapath.sv
// ----------------------------------------------------------------------------
// ncq_datapath: codebook memory and distance pipeline
// One codeword row read per cycle, per-lane squared differences, a two-way
// partial sum and a running minimum with lowest-index tie breaking.
// ----------------------------------------------------------------------------
module ncq_datapath import ncq_pkg::*; #(
	parameter int MAX_CODEWORDS  = 256,
	parameter int MAX_DIMENSION  = 8,
	parameter int COMPONENT_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ncq_cmd_t                              cmd,
	input  logic [$clog2(MAX_CODEWORDS)-1:0]      rd_addr,
	input  logic [INDEX_W-1:0]                    entry_index,
	input  logic [N_COMPONENTS-1:0][COMPONENT_BITS-1:0] comp,
	input  logic                                  last_vector,
	output ncq_stat_t                             stat,
	output logic [INDEX_W-1:0]                    nearest_index,
	output logic                                  batch_end
);

	localparam int IDX_W  = $clog2(MAX_CODEWORDS);
	localparam int CB     = COMPONENT_BITS;
	localparam int SQ_W   = 2 * CB + 1;
	localparam int DIST_W = SQ_W + $clog2(MAX_DIMENSION);
	localparam int HALF   = (MAX_DIMENSION + 1) / 2;

	logic [MAX_DIMENSION*CB-1:0] mem [MAX_CODEWORDS];
	logic [MAX_DIMENSION*CB-1:0] wr_row;
	logic                        wr_ok;

	logic [MAX_DIMENSION-1:0][CB-1:0] vec_q;
	logic [MAX_DIMENSION-1:0]         used_q;
	logic                             last_q;
	logic [3:0]                       dim_n;

	logic [MAX_DIMENSION*CB-1:0] row_s1;
	logic                        vld_s1, first_s1, last_s1;
	logic [IDX_W-1:0]            idx_s1;

	logic [MAX_DIMENSION-1:0][SQ_W-1:0] sq_d;
	logic [MAX_DIMENSION-1:0][SQ_W-1:0] sq_s2;
	logic                               vld_s2, first_s2, last_s2;
	logic [IDX_W-1:0]                   idx_s2;

	logic [DIST_W-1:0] pa_d, pb_d;
	logic [DIST_W-1:0] pa_s3, pb_s3;
	logic              vld_s3, first_s3, last_s3;
	logic [IDX_W-1:0]  idx_s3;

	logic [DIST_W-1:0] row_dist;
	logic [DIST_W-1:0] best_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic              res_end_q;

	always_comb begin
		for (int p = 0; p < MAX_DIMENSION; p++) begin
			wr_row[p*CB +: CB] = comp[p];
		end
	end

	assign wr_ok = ({1'b0, entry_index} < (INDEX_W + 1)'(MAX_CODEWORDS));

	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_ok) begin
			mem[entry_index[IDX_W-1:0]] <= wr_row;
		end
		if (cmd.rd_en) begin
			row_s1 <= mem[rd_addr];
		end
	end

	assign dim_n = 4'd1 << cmd.dim_code;

	// capture the vector and the lanes in use for the whole search
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int p = 0; p < MAX_DIMENSION; p++) begin
				vec_q[p]  <= comp[p];
				used_q[p] <= (4'(p) < dim_n);
			end
			last_q <= last_vector;
		end
	end

	always_comb begin
		logic signed [CB:0]     diff;
		logic signed [2*CB+1:0] prod;
		for (int p = 0; p < MAX_DIMENSION; p++) begin
			diff = $signed({vec_q[p][CB-1], vec_q[p]})
				- $signed({row_s1[p*CB+CB-1], row_s1[p*CB +: CB]});
			prod = diff * diff;
			sq_d[p] = used_q[p] ? prod[SQ_W-1:0] : '0;
		end
	end

	always_comb begin
		pa_d = '0;
		pb_d = '0;
		for (int p = 0; p < HALF; p++) begin
			pa_d = pa_d + DIST_W'(sq_s2[p]);
		end
		for (int p = HALF; p < MAX_DIMENSION; p++) begin
			pb_d = pb_d + DIST_W'(sq_s2[p]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.rd_first;
		last_s1  <= cmd.rd_last;
		idx_s1   <= rd_addr;
		sq_s2    <= sq_d;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		idx_s2   <= idx_s1;
		pa_s3    <= pa_d;
		pb_s3    <= pb_d;
		first_s3 <= first_s2;
		last_s3  <= last_s2;
		idx_s3   <= idx_s2;
	end

	assign row_dist = pa_s3 + pb_s3;

	// strict compare keeps the lower index on a tie
	always_ff @(posedge clk) begin
		if (vld_s3 && (first_s3 || row_dist < best_q)) begin
			best_q     <= row_dist;
			best_idx_q <= idx_s3;
		end
		if (cmd.load_result) begin
			res_idx_q <= best_idx_q;
			res_end_q <= last_q;
		end
	end

	assign stat.done     = vld_s3 && last_s3;
	assign nearest_index = INDEX_W'(res_idx_q);
	assign batch_end     = res_end_q;

endmodule

FILE: rtl/nearest_codeword_quantizer_core.sv
// ----------------------------------------------------------------------------
// nearest_codeword_quantizer_core: nearest codeword search over a codebook
// Top level joining the controller and the datapath to the channels.
// ----------------------------------------------------------------------------
// A load item writes one codeword row. A quantize item compares its vector
// against one codeword per cycle over the active codewords after
// saturation; the single read port of the codebook memory sets that pace.
// The result sits in an output register, and the next item is taken while
// it waits there. A codeword slot must be loaded before a search reads it.
module nearest_codeword_quantizer_core import ncq_pkg::*; #(
	parameter int MAX_CODEWORDS  = 256,
	parameter int MAX_DIMENSION  = 8,
	parameter int COMPONENT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	ncq_req_if.sink               req,
	ncq_rsp_if.source             rsp
);

	localparam int IDX_W = $clog2(MAX_CODEWORDS);

	ncq_cmd_t   cmd;
	ncq_stat_t  stat;
	logic [IDX_W-1:0] rd_addr;
	logic [N_COMPONENTS-1:0][COMPONENT_BITS-1:0] comp;

	assign comp[0] = req.component_0;
	assign comp[1] = req.component_1;
	assign comp[2] = req.component_2;
	assign comp[3] = req.component_3;
	assign comp[4] = req.component_4;
	assign comp[5] = req.component_5;
	assign comp[6] = req.component_6;
	assign comp[7] = req.component_7;

	ncq_ctrl #(
		.MAX_CODEWORDS (MAX_CODEWORDS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (req.valid),
		.in_op     (req.op),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.rd_addr   (rd_addr),
		.cmd       (cmd),
		.stat      (stat)
	);

	ncq_datapath #(
		.MAX_CODEWORDS  (MAX_CODEWORDS),
		.MAX_DIMENSION  (MAX_DIMENSION),
		.COMPONENT_BITS (COMPONENT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.rd_addr       (rd_addr),
		.entry_index   (req.entry_index),
		.comp          (comp),
		.last_vector   (req.last_vector),
		.stat          (stat),
		.nearest_index (rsp.nearest_index),
		.batch_end     (rsp.batch_end)
	);

`ifndef ASSERT_OFF
	// a quantize transfer must take the block out of the idle state
	a_busy_after_quant: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.op == OP_QUANT |=> !req.ready)
		else $error("input still ready after a quantize transfer");

	// the end of a search never lands while new items are taken
	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> !req.ready)
		else $error("search finished while the block was idle");

	// a moved result is presented in the next cycle
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |=> rsp.valid)
		else $error("result loaded but not presented");

	// reads are issued only during a search, never alongside a load
	a_read_excl_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !cmd.wr_en && !req.ready)
		else $error("codebook read outside a search");
`endif

endmodule

FILE: tb/sv/ncq_nearest_index_check.sv
// ----------------------------------------------------------------------------
// ncq_nearest_index_check: result checker of the nearest codeword quantizer
// Watches the register port and both channels, keeps its own copy of the
// codebook and registers, works out the nearest codeword for every quantize
// transfer and compares each response against the oldest outstanding one.
// ----------------------------------------------------------------------------
module ncq_nearest_index_check import ncq_pkg::*; #(
	parameter int COMP_W = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	ncq_req_if                    req,
	ncq_rsp_if                    rsp,
	output int unsigned           mismatches,
	output int unsigned           outstanding
);

	localparam int BOOK_SLOTS = 256;

	typedef struct packed {
		logic [INDEX_W-1:0] nearest_index;
		logic               batch_end;
	} index_result_t;

	logic signed [COMP_W-1:0] book [BOOK_SLOTS][N_COMPONENTS];
	logic signed [COMP_W-1:0] item_comp [N_COMPONENTS];
	logic [ACTIVE_W-1:0]      active_codewords;
	logic [DIM_CODE_W-1:0]    dim_code;
	index_result_t            pending_indices [$];

	assign item_comp[0] = req.component_0;
	assign item_comp[1] = req.component_1;
	assign item_comp[2] = req.component_2;
	assign item_comp[3] = req.component_3;
	assign item_comp[4] = req.component_4;
	assign item_comp[5] = req.component_5;
	assign item_comp[6] = req.component_6;
	assign item_comp[7] = req.component_7;

	// Exact squared distances; a strict compare keeps the lowest slot on ties.
	function automatic logic [INDEX_W-1:0] nearest_codeword();
		int unsigned     searched;
		int unsigned     used;
		int unsigned     best_slot;
		longint unsigned sum_sq;
		longint unsigned lowest_sum;
		longint          diff;
		longint unsigned sq;
		if (active_codewords == 0)
			searched = 1;
		else if (active_codewords > BOOK_SLOTS)
			searched = BOOK_SLOTS;
		else
			searched = int'(active_codewords);
		used = 1 << dim_code;
		best_slot = 0;
		lowest_sum = 0;
		for (int unsigned slot = 0; slot < searched; slot++) begin
			sum_sq = 0;
			for (int unsigned p = 0; p < used; p++) begin
				diff = longint'(item_comp[p]) - longint'(book[slot][p]);
				sq = diff * diff;
				sum_sq += sq;
			end
			if (slot == 0 || sum_sq < lowest_sum) begin
				lowest_sum = sum_sq;
				best_slot = slot;
			end
		end
		return best_slot[INDEX_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		index_result_t seen;
		index_result_t want;
		int unsigned   fails;
		if (!arst_n) begin
			active_codewords = ACTIVE_RST;
			dim_code = DIM_RST;
			pending_indices.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			fails = mismatches;
			if (cfg_we) begin
				if (cfg_index == CFG_ACTIVE)
					active_codewords = cfg_wdata[ACTIVE_W-1:0];
				else if (cfg_index == CFG_DIM)
					dim_code = cfg_wdata[DIM_CODE_W-1:0];
			end
			// retire the response first: it always belongs to an earlier item
			if (rsp.valid && rsp.ready) begin
				seen = '{nearest_index: rsp.nearest_index, batch_end: rsp.batch_end};
				if (pending_indices.size() == 0) begin
					if (fails < 10)
						$display("%0t: unexpected response: index %0d batch_end %0b",
							$time, seen.nearest_index, seen.batch_end);
					fails++;
				end else begin
					want = pending_indices.pop_front();
					if (seen.nearest_index !== want.nearest_index ||
						seen.batch_end !== want.batch_end) begin
						if (fails < 10)
							$display("%0t: response mismatch: expected index %0d batch_end %0b, got index %0d batch_end %0b",
								$time, want.nearest_index, want.batch_end,
								seen.nearest_index, seen.batch_end);
						fails++;
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.op == OP_QUANT)
					pending_indices.push_back('{nearest_index: nearest_codeword(),
						batch_end: req.last_vector});
				else
					for (int p = 0; p < N_COMPONENTS; p++)
						book[req.entry_index][p] = item_comp[p];
			end
			mismatches <= fails;
			outstanding <= pending_indices.size();
		end
	end

endmodule

FILE: tb/sv/tb_nearest_codeword_quantizer_core.sv
// ----------------------------------------------------------------------------
// tb_nearest_codeword_quantizer_core: testbench of the codeword quantizer
// Loads codebooks and quantizes vectors under a range of register settings,
// directed corner items first, then random phases with bursty requests and a
// stalling response side; the index checker judges every response.
// ----------------------------------------------------------------------------
module tb_nearest_codeword_quantizer_core;
	import ncq_pkg::*;

	localparam int     COMP_W        = 16;
	localparam int     BOOK_SLOTS    = 256;
	localparam int     PHASE_ITEMS   = 1680;
	localparam int     SETTLE_CYCLES = 8;
	localparam int     DRAIN_CYCLES  = 300;
	localparam int     FILL_W        = CFG_DATA_W - DIM_CODE_W;
	localparam longint RUN_LIMIT     = 40_000_000;

	typedef logic [N_COMPONENTS-1:0][COMP_W-1:0] comp_vec_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int unsigned           mismatches;
	int unsigned           outstanding;

	comp_vec_t             shadow_book [BOOK_SLOTS];
	logic [ACTIVE_W-1:0]   active_setting;
	int                    burst_left;

	ncq_req_if #(.COMPONENT_BITS(COMP_W)) req_ch ();
	ncq_rsp_if rsp_ch ();

	nearest_codeword_quantizer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	ncq_nearest_index_check #(.COMP_W(COMP_W)) index_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(RUN_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	// Response side: each stretch picks a stall style, full rate among them.
	initial begin : response_sink
		logic [15:0] stall_word;
		int          mode;
		int          stretch;
		rsp_ch.ready <= 1'b0;
		stall_word = '0;
		mode = 0;
		stretch = 0;
		forever begin
			@(posedge clk);
			if (stretch == 0) begin
				mode = $urandom_range(0, 3);
				stretch = $urandom_range(16, 96);
				stall_word = 16'($urandom);
			end
			stretch--;
			case (mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
				2: begin
					rsp_ch.ready <= stall_word[0];
					stall_word = {stall_word[0], stall_word[15:1]};
				end
				default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	function automatic int search_span();
		if (active_setting == 0)
			return 1;
		if (active_setting > BOOK_SLOTS)
			return BOOK_SLOTS;
		return int'(active_setting);
	endfunction

	function automatic logic [COMP_W-1:0] extreme_component();
		case ($urandom_range(0, 4))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'h0001;
		endcase
	endfunction

	// Move a component by up to spread either way, held within the signed range.
	function automatic logic [COMP_W-1:0] nudge(input logic [COMP_W-1:0] base, input int spread);
		int v;
		v = int'($signed(base)) + int'($urandom_range(0, 2 * spread)) - spread;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[COMP_W-1:0];
	endfunction

	// Codewords: extremes and near or exact duplicates give ties and close calls.
	function automatic comp_vec_t new_codeword();
		comp_vec_t cw;
		comp_vec_t src;
		src = shadow_book[$urandom_range(0, BOOK_SLOTS - 1)];
		case ($urandom_range(0, 7))
			0, 1: for (int p = 0; p < N_COMPONENTS; p++) cw[p] = extreme_component();
			2: cw = src;
			3: for (int p = 0; p < N_COMPONENTS; p++) cw[p] = nudge(src[p], 4);
			default: for (int p = 0; p < N_COMPONENTS; p++) cw[p] = COMP_W'($urandom);
		endcase
		return cw;
	endfunction

	// Vectors: mostly close to a codeword inside the searched range.
	function automatic comp_vec_t new_vector();
		comp_vec_t v;
		comp_vec_t src;
		src = shadow_book[$urandom_range(0, search_span() - 1)];
		case ($urandom_range(0, 9))
			0, 1: v = src;
			2, 3, 4: for (int p = 0; p < N_COMPONENTS; p++) v[p] = nudge(src[p], 64);
			5: for (int p = 0; p < N_COMPONENTS; p++) v[p] = nudge(src[p], 2000);
			6: for (int p = 0; p < N_COMPONENTS; p++) v[p] = extreme_component();
			default: for (int p = 0; p < N_COMPONENTS; p++) v[p] = COMP_W'($urandom);
		endcase
		return v;
	endfunction

	// Call at a rising edge; returns at the edge of the transfer.
	task automatic drive_item(input logic op, input logic [INDEX_W-1:0] slot,
		input comp_vec_t comps, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.entry_index <= slot;
		req_ch.last_vector <= last;
		req_ch.component_0 <= comps[0];
		req_ch.component_1 <= comps[1];
		req_ch.component_2 <= comps[2];
		req_ch.component_3 <= comps[3];
		req_ch.component_4 <= comps[4];
		req_ch.component_5 <= comps[5];
		req_ch.component_6 <= comps[6];
		req_ch.component_7 <= comps[7];
		do @(posedge clk); while (!req_ch.ready);
		if (op == OP_LOAD)
			shadow_book[slot] = comps;
	endtask

	// Drop valid and hold until every response is back and any load has landed.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_registers(input logic [ACTIVE_W-1:0] active,
		input logic [DIM_CODE_W-1:0] dim);
		logic [FILL_W-1:0] filler;
		filler = FILL_W'($urandom);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ACTIVE;
		cfg_wdata <= active;
		@(posedge clk);
		// upper bits of the dimension write are don't-care
		cfg_index <= CFG_DIM;
		cfg_wdata <= {filler, dim};
		@(posedge clk);
		cfg_we <= 1'b0;
		active_setting = active;
	endtask

	initial begin : stimulus
		logic [ACTIVE_W-1:0]   active;
		logic [DIM_CODE_W-1:0] dim;
		int                    phase_no;
		int                    sent;
		int                    count;
		int                    pick;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ACTIVE;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.op <= OP_LOAD;
		req_ch.entry_index <= '0;
		req_ch.last_vector <= 1'b0;
		req_ch.component_0 <= '0;
		req_ch.component_1 <= '0;
		req_ch.component_2 <= '0;
		req_ch.component_3 <= '0;
		req_ch.component_4 <= '0;
		req_ch.component_5 <= '0;
		req_ch.component_6 <= '0;
		req_ch.component_7 <= '0;
		burst_left = 0;
		active_setting = ACTIVE_RST;
		for (int s = 0; s < BOOK_SLOTS; s++)
			shadow_book[s] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: full-scale codewords, a tied pair and the top slot.
		program_registers(9'd4, 2'd3);
		drive_item(OP_LOAD, 8'd0, {N_COMPONENTS{16'h7fff}}, 1'b0);
		drive_item(OP_LOAD, 8'd1, {N_COMPONENTS{16'h8000}}, 1'b1);
		drive_item(OP_LOAD, 8'd2, '0, 1'b0);
		drive_item(OP_LOAD, 8'd3, '0, 1'b0);
		drive_item(OP_LOAD, 8'd255, {N_COMPONENTS{16'haaaa}}, 1'b1);
		drive_item(OP_QUANT, 8'hff, {N_COMPONENTS{16'h7fff}}, 1'b0);
		drive_item(OP_QUANT, 8'h00, {N_COMPONENTS{16'h8000}}, 1'b1);
		drive_item(OP_QUANT, 8'h55, '0, 1'b1);
		drive_item(OP_QUANT, 8'haa, {(N_COMPONENTS / 2){16'h7fff, 16'h8000}}, 1'b0);
		drive_item(OP_QUANT, 8'h0f, {N_COMPONENTS{16'h0001}}, 1'b0);
		drive_item(OP_QUANT, 8'hf0, {N_COMPONENTS{16'h5555}}, 1'b1);
		wait_idle();
		// zero active codewords: slot 0 alone is searched
		program_registers(9'd0, 2'd3);
		drive_item(OP_QUANT, 8'h00, {N_COMPONENTS{16'h8000}}, 1'b1);
		wait_idle();
		// one component used; the rest sit at the far extreme
		program_registers(9'd2, 2'd0);
		drive_item(OP_QUANT, 8'h00, {{(N_COMPONENTS - 1){16'h7fff}}, 16'h8000}, 1'b0);
		wait_idle();
		// two components, equal distance to slots 0 and 1
		program_registers(9'd2, 2'd1);
		drive_item(OP_QUANT, 8'h00, {{(N_COMPONENTS - 2){16'h0000}}, 16'h7fff, 16'h8000}, 1'b1);
		wait_idle();

		// Fill the whole codebook so every later search reads loaded slots.
		for (int s = 0; s < BOOK_SLOTS; s++)
			drive_item(OP_LOAD, s[INDEX_W-1:0], new_codeword(), 1'($urandom));
		wait_idle();

		phase_no = 0;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			case (phase_no)
				0: begin active = 9'd1;   dim = 2'd1; end
				1: begin active = 9'd256; dim = 2'd3; end
				2: begin active = 9'd511; dim = 2'd2; end
				3: begin active = 9'd257; dim = 2'd0; end
				4: begin active = 9'd0;   dim = 2'd2; end
				default: begin
					pick = $urandom_range(0, 19);
					if (pick == 0)
						active = 9'd0;
					else if (pick == 1)
						active = 9'd256;
					else if (pick == 2)
						active = ACTIVE_W'($urandom_range(257, 511));
					else if (pick < 6)
						active = ACTIVE_W'($urandom_range(17, 255));
					else
						active = ACTIVE_W'($urandom_range(1, 16));
					dim = DIM_CODE_W'($urandom_range(0, 3));
				end
			endcase
			program_registers(active, dim);
			// keep wide searches short; they cost a cycle per codeword
			count = (search_span() > 16) ? $urandom_range(15, 30) : $urandom_range(40, 80);
			repeat (count) begin
				if ($urandom_range(0, 4) == 0)
					drive_item(OP_LOAD, ($urandom_range(0, 3) != 0)
						? INDEX_W'($urandom_range(0, search_span() - 1))
						: INDEX_W'($urandom_range(0, BOOK_SLOTS - 1)),
						new_codeword(), 1'($urandom));
				else
					drive_item(OP_QUANT, INDEX_W'($urandom), new_vector(),
						$urandom_range(0, 4) == 0);
				sent++;
			end
			wait_idle();
			phase_no++;
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
